// ===== src/usbb_pkg.sv =====
// Package with the shared types and constants of the UART to SPI burst bridge.
package usbb_pkg;

	localparam int DEF_BUFFER_DEPTH = 128;

	localparam logic [7:0] ACK_CODE_RST    = 8'hAA;
	localparam logic [7:0] FILLER_BYTE_RST = 8'h5A;
	localparam logic [7:0] WRITE_FLAG      = 8'h80;

	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_ACK_CODE    = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FILLER_BYTE = 1'd1;

	typedef enum logic [1:0] {
		FUNC_UART_RX  = 2'd0,
		FUNC_SPI_DONE = 2'd1,
		FUNC_UART_RDY = 2'd2
	} func_t;

	typedef enum logic [3:0] {
		PH_ADDR       = 4'd0,
		PH_CHECK_ADDR = 4'd1,
		PH_NUM        = 4'd2,
		PH_CHECK_NUM  = 4'd3,
		PH_FILL       = 4'd4,
		PH_WRITE      = 4'd5,
		PH_READ_ADDR  = 4'd6,
		PH_READ       = 4'd7,
		PH_RETURN     = 4'd8
	} phase_t;

	typedef struct packed {
		logic       uart_send;
		logic [7:0] uart_data;
		logic       uart_from_mem;
		logic       spi_send;
		logic [7:0] spi_data;
		logic       spi_from_mem;
		logic       select_active;
		logic       handshake_error;
		logic       transaction_done;
	} result_t;

endpackage

// ===== src/uart_to_spi_burst_bridge_core.sv =====
// Top level of the UART to SPI burst bridge: handshake sequencer and burst buffer.
//
// The bridge takes one event per clock cycle while in_stall is low and returns exactly one
// result per event. The pipeline is set by the burst buffer, a single
// synchronous memory with a registered read port: the first stage updates the handshake
// state and issues the buffer read and write, the second stage merges the read data into the
// result and holds it in the output register. When the output is stalled, one more event is
// still taken before the input stalls. The buffer holds no reset value and needs no clearing
// pass; an entry is only read after the current transaction wrote it.
module uart_to_spi_burst_bridge_core #(
	parameter int BUFFER_DEPTH = usbb_pkg::DEF_BUFFER_DEPTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [usbb_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [7:0]                     cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [1:0]                     func,
	input  logic [7:0]                     data_byte,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           uart_send,
	output logic [7:0]                     uart_data,
	output logic                           spi_send,
	output logic [7:0]                     spi_data,
	output logic                           select_active,
	output logic                           handshake_error,
	output logic                           transaction_done
);
	import usbb_pkg::*;

	localparam int         AW     = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
	localparam logic [7:0] DEPTH_B = 8'(BUFFER_DEPTH);

	logic [7:0] ack_q;
	logic [7:0] filler_q;

	phase_t     phase_q, phase_d;
	logic [7:0] addr_q, addr_d;
	logic [7:0] len_q, len_d;
	logic [7:0] fill_q, fill_d;
	logic [7:0] drain_q, drain_d;
	logic       sel_q, sel_d;

	logic [7:0] buf_mem [BUFFER_DEPTH];
	logic          mem_we;
	logic [AW-1:0] mem_wa;
	logic          mem_re;
	logic [AW-1:0] mem_ra;

	logic       acc;
	logic       hit_ack;
	logic [7:0] fill_inc;
	logic [7:0] drain_inc;
	logic [7:0] sat_len;
	result_t    res_d;

	logic       v_s1;
	result_t    res_s1;
	logic       fwd_s1;
	logic [7:0] fwd_data_s1;
	logic [7:0] rd_s1;
	logic       adv_s1;
	logic [7:0] mem_byte;
	result_t    res_mrg;

	logic       v_s2;
	result_t    res_s2;

	assign adv_s1   = v_s1 && (!v_s2 || !out_stall);
	assign in_stall = v_s1 && !adv_s1;
	assign acc      = in_valid && !in_stall;

	assign hit_ack   = (data_byte == ack_q);
	assign fill_inc  = fill_q + 8'd1;
	assign drain_inc = drain_q + 8'd1;
	assign sat_len   = (data_byte > DEPTH_B) ? DEPTH_B : data_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ack_q    <= ACK_CODE_RST;
			filler_q <= FILLER_BYTE_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_ACK_CODE:    ack_q    <= cfg_data;
				REG_FILLER_BYTE: filler_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		phase_d = phase_q;
		addr_d  = addr_q;
		len_d   = len_q;
		fill_d  = fill_q;
		drain_d = drain_q;
		sel_d   = sel_q;
		mem_we  = 1'b0;
		mem_wa  = fill_q[AW-1:0];
		mem_re  = 1'b0;
		mem_ra  = drain_q[AW-1:0];
		if (acc) begin
			unique case (func)
				FUNC_UART_RX: begin
					unique case (phase_q)
						PH_ADDR: begin
							addr_d  = data_byte;
							phase_d = PH_CHECK_ADDR;
						end
						PH_CHECK_ADDR, PH_CHECK_NUM: begin
							if (!hit_ack) begin
								phase_d = PH_ADDR;
								addr_d  = '0;
								len_d   = '0;
								fill_d  = '0;
								drain_d = '0;
								sel_d   = 1'b0;
							end else if (phase_q == PH_CHECK_ADDR) begin
								phase_d = PH_NUM;
							end else if ((addr_q & WRITE_FLAG) != '0) begin
								if (len_q == '0) begin
									sel_d   = 1'b1;
									phase_d = PH_WRITE;
								end else begin
									phase_d = PH_FILL;
								end
							end else begin
								sel_d   = 1'b1;
								phase_d = PH_READ_ADDR;
							end
						end
						PH_NUM: begin
							len_d   = sat_len;
							phase_d = PH_CHECK_NUM;
						end
						PH_FILL: begin
							mem_we = 1'b1;
							fill_d = fill_inc;
							if (fill_inc >= len_q) begin
								sel_d   = 1'b1;
								phase_d = PH_WRITE;
							end
						end
						default: ;
					endcase
				end
				FUNC_SPI_DONE: begin
					unique case (phase_q)
						PH_WRITE: begin
							if (drain_q < len_q) begin
								mem_re  = 1'b1;
								drain_d = drain_inc;
							end else begin
								phase_d = PH_ADDR;
								addr_d  = '0;
								len_d   = '0;
								fill_d  = '0;
								drain_d = '0;
								sel_d   = 1'b0;
							end
						end
						PH_READ_ADDR: begin
							if (len_q == '0) begin
								phase_d = PH_ADDR;
								addr_d  = '0;
								len_d   = '0;
								fill_d  = '0;
								drain_d = '0;
								sel_d   = 1'b0;
							end else begin
								phase_d = PH_READ;
							end
						end
						PH_READ: begin
							mem_we = 1'b1;
							fill_d = fill_inc;
							if (fill_inc >= len_q) begin
								mem_re  = 1'b1;
								mem_ra  = '0;
								sel_d   = 1'b0;
								drain_d = 8'd1;
								if (len_q <= 8'd1) begin
									phase_d = PH_ADDR;
									addr_d  = '0;
									len_d   = '0;
									fill_d  = '0;
									drain_d = '0;
								end else begin
									phase_d = PH_RETURN;
								end
							end
						end
						default: ;
					endcase
				end
				FUNC_UART_RDY: begin
					if (phase_q == PH_RETURN) begin
						if (drain_q < len_q) begin
							mem_re  = 1'b1;
							drain_d = drain_inc;
						end
						if ((drain_q < len_q ? drain_inc : drain_q) >= len_q) begin
							phase_d = PH_ADDR;
							addr_d  = '0;
							len_d   = '0;
							fill_d  = '0;
							drain_d = '0;
							sel_d   = 1'b0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		res_d               = '0;
		res_d.select_active = sel_d;
		unique case (func)
			FUNC_UART_RX: begin
				unique case (phase_q)
					PH_ADDR: begin
						res_d.uart_send = 1'b1;
						res_d.uart_data = data_byte;
					end
					PH_CHECK_ADDR, PH_CHECK_NUM: begin
						if (!hit_ack) begin
							res_d.handshake_error = 1'b1;
						end else if (phase_q == PH_CHECK_NUM) begin
							if ((addr_q & WRITE_FLAG) == '0 || len_q == '0) begin
								res_d.spi_send = 1'b1;
								res_d.spi_data = addr_q;
							end
						end
					end
					PH_NUM: begin
						res_d.uart_send = 1'b1;
						res_d.uart_data = sat_len;
					end
					PH_FILL: begin
						if (fill_inc >= len_q) begin
							res_d.spi_send = 1'b1;
							res_d.spi_data = addr_q;
						end
					end
					default: ;
				endcase
			end
			FUNC_SPI_DONE: begin
				unique case (phase_q)
					PH_WRITE: begin
						if (drain_q < len_q) begin
							res_d.spi_send     = 1'b1;
							res_d.spi_from_mem = 1'b1;
						end else begin
							res_d.transaction_done = 1'b1;
						end
					end
					PH_READ_ADDR: begin
						if (len_q == '0) begin
							res_d.transaction_done = 1'b1;
						end else begin
							res_d.spi_send = 1'b1;
							res_d.spi_data = filler_q;
						end
					end
					PH_READ: begin
						if (fill_inc < len_q) begin
							res_d.spi_send = 1'b1;
							res_d.spi_data = filler_q;
						end else begin
							res_d.uart_send        = 1'b1;
							res_d.uart_from_mem    = 1'b1;
							res_d.transaction_done = (len_q <= 8'd1);
						end
					end
					default: ;
				endcase
			end
			FUNC_UART_RDY: begin
				if (phase_q == PH_RETURN) begin
					if (drain_q < len_q) begin
						res_d.uart_send     = 1'b1;
						res_d.uart_from_mem = 1'b1;
					end
					res_d.transaction_done =
						((drain_q < len_q ? drain_inc : drain_q) >= len_q);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_ADDR;
			addr_q  <= '0;
			len_q   <= '0;
			fill_q  <= '0;
			drain_q <= '0;
			sel_q   <= 1'b0;
		end else begin
			phase_q <= phase_d;
			addr_q  <= addr_d;
			len_q   <= len_d;
			fill_q  <= fill_d;
			drain_q <= drain_d;
			sel_q   <= sel_d;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			buf_mem[mem_wa] <= data_byte;
		end
		if (mem_re) begin
			rd_s1 <= buf_mem[mem_ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (acc) begin
			v_s1 <= 1'b1;
		end else if (adv_s1) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			res_s1      <= res_d;
			fwd_s1      <= mem_we && mem_re && (mem_wa == mem_ra);
			fwd_data_s1 <= data_byte;
		end
	end

	assign mem_byte = fwd_s1 ? fwd_data_s1 : rd_s1;

	always_comb begin
		res_mrg = res_s1;
		if (res_s1.uart_from_mem) begin
			res_mrg.uart_data = mem_byte;
		end
		if (res_s1.spi_from_mem) begin
			res_mrg.spi_data = mem_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv_s1) begin
			v_s2 <= 1'b1;
		end else if (!out_stall) begin
			v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_s2 <= res_mrg;
		end
	end

	assign out_valid        = v_s2;
	assign uart_send        = res_s2.uart_send;
	assign uart_data        = res_s2.uart_data;
	assign spi_send         = res_s2.spi_send;
	assign spi_data         = res_s2.spi_data;
	assign select_active    = res_s2.select_active;
	assign handshake_error  = res_s2.handshake_error;
	assign transaction_done = res_s2.transaction_done;

	a_addr_echo: assert property (@(posedge clk) disable iff (!arst_n)
		acc && phase_q == PH_ADDR && func == FUNC_UART_RX |=> phase_q == PH_CHECK_ADDR)
		else $error("Address byte did not advance the handshake.");

	a_select_phase: assert property (@(posedge clk) disable iff (!arst_n)
		sel_q |-> (phase_q == PH_WRITE || phase_q == PH_READ_ADDR || phase_q == PH_READ))
		else $error("Chip select held outside an SPI phase.");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_FILL || phase_q == PH_READ) |-> fill_q < len_q)
		else $error("Fill index reached the burst length inside a fill phase.");

	a_return_bound: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_RETURN |-> (drain_q < len_q && drain_q != '0))
		else $error("Return phase has no byte left to send.");

	a_len_sat: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= DEPTH_B)
		else $error("Burst length exceeds the buffer depth.");

endmodule
